@@ sv/itg_pkg.sv @@
// Shared types, register indexes and reset values of the idle timeout gate.
package itg_pkg;

   localparam int COUNT_WIDTH_DEF  = 24;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int PULSE_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH   = 3;

   localparam int RST_BASE_TIMEOUT = 12000;
   localparam int RST_EDGE_HIGH    = 3277;
   localparam int RST_EDGE_LOW     = 0;
   localparam int RST_PULSE_WIDTH  = 480;
   localparam int RST_TIME_LIMIT   = 480000;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_CLOCK_MODE      = 3'd0,
      CSR_BASE_TIMEOUT    = 3'd1,
      CSR_EDGE_HIGH_LEVEL = 3'd2,
      CSR_EDGE_LOW_LEVEL  = 3'd3,
      CSR_PULSE_WIDTH     = 3'd4,
      CSR_HEARTBEAT_EN    = 3'd5,
      CSR_SOURCE_EN       = 3'd6,
      CSR_TIME_LIMIT      = 3'd7
   } csr_index_type;

endpackage

@@ sv/itg_edge_det.sv @@
// Hysteresis rising-edge detector with its own armed flag.
module itg_edge_det import itg_pkg::*; #(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           enable,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [SAMPLE_WIDTH-1:0] high_level,
   input  logic signed [SAMPLE_WIDTH-1:0] low_level,
   output logic                           edge_found
);

   logic armed_ff;
   logic armed_in;

   always_comb begin
      armed_in   = armed_ff;
      edge_found = 1'b0;
      if (enable) begin
         if (armed_ff) begin
            if (sample <= low_level) begin
               armed_in = 1'b0;
            end
         end else if (sample >= high_level) begin
            armed_in   = 1'b1;
            edge_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else if (step) begin
         armed_ff <= armed_in;
      end
   end

endmodule

@@ sv/itg_pulse.sv @@
// Retriggerable pulse stretcher counting down in frames.
module itg_pulse import itg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   trigger,
   input  logic [PULSE_WIDTH-1:0] width,
   output logic                   pulse
);

   logic [PULSE_WIDTH-1:0] left_ff;
   logic [PULSE_WIDTH-1:0] loaded;
   logic [PULSE_WIDTH-1:0] left_in;

   always_comb begin
      loaded  = (trigger && (width > left_ff)) ? width : left_ff;
      pulse   = (loaded != '0);
      left_in = pulse ? loaded - PULSE_WIDTH'(1) : loaded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (step) begin
         left_ff <= left_in;
      end
   end

endmodule

@@ sv/idle_timeout_gate.sv @@
// Idle timeout gate: one sample per transaction, idle when no source edge arrives in time.
// The gate takes one transaction per clock cycle unless the result port stalls it:
// the transaction waits in the input register, and when the result register is free
// the timing logic loads the result register and updates the frame counter, idle flag,
// edge detectors and pulse counters. A stalled result port holds the result register and
// still lets one more transaction into the input register. The user must write registers
// through the csr port only while no transaction is in flight; the gate does not enforce this.
module idle_timeout_gate import itg_pkg::*; #(
   parameter  int COUNT_WIDTH    = COUNT_WIDTH_DEF,
   parameter  int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   localparam int REQ_BITS       = 4 * SAMPLE_WIDTH + COUNT_WIDTH,
   localparam int REQ_DATA_WIDTH = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS       = 3 + 2 * SAMPLE_WIDTH + 2 * COUNT_WIDTH,
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8,
   localparam int CSR_DATA_WIDTH = (COUNT_WIDTH > SAMPLE_WIDTH) ?
      ((COUNT_WIDTH > PULSE_WIDTH) ? COUNT_WIDTH : PULSE_WIDTH) :
      ((SAMPLE_WIDTH > PULSE_WIDTH) ? SAMPLE_WIDTH : PULSE_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // source_sample, heartbeat_sample, clock_sample, switched_sample, timeout_cv_frames
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // idle_gate, on_when_idle, off_when_idle, idle_start, idle_end,
   // time_value_frames, frames remaining before idle
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COUNT_WIDTH;

   // configuration
   logic                 clock_mode_ff;
   logic [CW-1:0]        base_timeout_ff;
   logic signed [SW-1:0] edge_high_ff;
   logic signed [SW-1:0] edge_low_ff;
   logic [PULSE_WIDTH-1:0] pulse_width_ff;
   logic                 heartbeat_en_ff;
   logic                 source_en_ff;
   logic [CW-1:0]        time_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_mode_ff   <= 1'b0;
         base_timeout_ff <= CW'(RST_BASE_TIMEOUT);
         edge_high_ff    <= SW'(RST_EDGE_HIGH);
         edge_low_ff     <= SW'(RST_EDGE_LOW);
         pulse_width_ff  <= PULSE_WIDTH'(RST_PULSE_WIDTH);
         heartbeat_en_ff <= 1'b0;
         source_en_ff    <= 1'b1;
         time_limit_ff   <= CW'(RST_TIME_LIMIT);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CLOCK_MODE:      clock_mode_ff   <= csr_wdata[0];
            CSR_BASE_TIMEOUT:    base_timeout_ff <= csr_wdata[CW-1:0];
            CSR_EDGE_HIGH_LEVEL: edge_high_ff    <= csr_wdata[SW-1:0];
            CSR_EDGE_LOW_LEVEL:  edge_low_ff     <= csr_wdata[SW-1:0];
            CSR_PULSE_WIDTH:     pulse_width_ff  <= csr_wdata[PULSE_WIDTH-1:0];
            CSR_HEARTBEAT_EN:    heartbeat_en_ff <= csr_wdata[0];
            CSR_SOURCE_EN:       source_en_ff    <= csr_wdata[0];
            CSR_TIME_LIMIT:      time_limit_ff   <= csr_wdata[CW-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake and input register
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [REQ_BITS-1:0] s1_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff;
   logic [RSP_BITS-1:0] rsp_data_in;
   logic                advance;
   logic                step;
   logic                req_take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata[REQ_BITS-1:0];
      end
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'(rsp_data_ff);

   logic signed [SW-1:0] source_sample;
   logic signed [SW-1:0] heartbeat_sample;
   logic signed [SW-1:0] clock_sample;
   logic [SW-1:0]        switched_sample;
   logic [CW-1:0]        timeout_cv_frames;

   assign source_sample     = s1_data_ff[SW-1:0];
   assign heartbeat_sample  = s1_data_ff[2*SW-1:SW];
   assign clock_sample      = s1_data_ff[3*SW-1:2*SW];
   assign switched_sample   = s1_data_ff[4*SW-1:3*SW];
   assign timeout_cv_frames = s1_data_ff[4*SW+CW-1:4*SW];

   // edge detectors
   logic clock_seen;
   logic heartbeat_edge;
   logic source_edge;

   itg_edge_det #(.SAMPLE_WIDTH(SW)) u_clock_det (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .enable     (clock_mode_ff),
      .sample     (clock_sample),
      .high_level (edge_high_ff),
      .low_level  (edge_low_ff),
      .edge_found (clock_seen)
   );

   itg_edge_det #(.SAMPLE_WIDTH(SW)) u_heartbeat_det (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .enable     (heartbeat_en_ff),
      .sample     (heartbeat_sample),
      .high_level (edge_high_ff),
      .low_level  (edge_low_ff),
      .edge_found (heartbeat_edge)
   );

   itg_edge_det #(.SAMPLE_WIDTH(SW)) u_source_det (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .enable     (source_en_ff),
      .sample     (source_sample),
      .high_level (edge_high_ff),
      .low_level  (edge_low_ff),
      .edge_found (source_edge)
   );

   // timing state
   logic [CW-1:0] frame_counter_ff;
   logic [CW-1:0] frame_counter_in;
   logic [CW-1:0] clock_mark_ff;
   logic [CW-1:0] clock_mark_in;
   logic          idle_ff;
   logic          idle_in;

   logic [CW:0]   timeout_sum;
   logic [CW-1:0] timeout_frames;
   logic [CW-1:0] clock_mark_now;
   logic [CW-1:0] time_raw;
   logic [CW-1:0] time_value;
   logic [CW-1:0] max_count;
   logic [CW-1:0] count_now;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] remaining_frames;
   logic          exceeded;
   logic          idle_now;
   logic          start_trigger;
   logic          end_trigger;
   logic          idle_start;
   logic          idle_end;

   always_comb begin
      timeout_sum    = {1'b0, base_timeout_ff} + {1'b0, timeout_cv_frames};
      timeout_frames = timeout_sum[CW] ? '1 : timeout_sum[CW-1:0];
      clock_mark_now = clock_seen ? frame_counter_ff : clock_mark_ff;

      if (clock_mode_ff) begin
         time_raw  = (frame_counter_ff > clock_mark_now) ?
                     frame_counter_ff - clock_mark_now : '0;
         max_count = frame_counter_ff;
      end else begin
         time_raw  = timeout_frames;
         max_count = timeout_frames;
      end
      time_value = (time_raw > time_limit_ff) ? time_limit_ff : time_raw;

      count_now     = heartbeat_edge ? '0 : frame_counter_ff;
      exceeded      = (count_now > max_count) || clock_seen;
      start_trigger = exceeded && !idle_ff;
      idle_now      = idle_ff || exceeded;

      if (!clock_mode_ff && !idle_now && (max_count > count_now)) begin
         remaining_frames = max_count - count_now;
      end else begin
         remaining_frames = '0;
      end

      count_inc   = (count_now != '1) ? count_now + CW'(1) : count_now;
      end_trigger = source_edge && idle_now;

      if (source_edge) begin
         idle_in          = 1'b0;
         frame_counter_in = '0;
         clock_mark_in    = '0;
      end else begin
         idle_in          = idle_now;
         frame_counter_in = count_inc;
         clock_mark_in    = clock_mark_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_counter_ff <= '0;
         clock_mark_ff    <= '0;
         idle_ff          <= 1'b0;
      end else if (step) begin
         frame_counter_ff <= frame_counter_in;
         clock_mark_ff    <= clock_mark_in;
         idle_ff          <= idle_in;
      end
   end

   itg_pulse u_start_pulse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .trigger (start_trigger),
      .width   (pulse_width_ff),
      .pulse   (idle_start)
   );

   itg_pulse u_end_pulse (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .trigger (end_trigger),
      .width   (pulse_width_ff),
      .pulse   (idle_end)
   );

   assign rsp_data_in = {
      remaining_frames,
      time_value,
      idle_end,
      idle_start,
      idle_now ? {SW{1'b0}} : switched_sample,
      idle_now ? switched_sample : {SW{1'b0}},
      idle_now
   };

endmodule

@@ sv/itg_checker.sv @@
// Port-level checks of the idle timeout gate and their binding to the top level.
module itg_checker import itg_pkg::*; #(
   parameter  int COUNT_WIDTH    = COUNT_WIDTH_DEF,
   parameter  int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   localparam int RSP_BITS       = 3 + 2 * SAMPLE_WIDTH + 2 * COUNT_WIDTH,
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CW     = COUNT_WIDTH;
   localparam int ON_LO  = 1;
   localparam int OFF_LO = 1 + SW;
   localparam int LEFT_LO = 3 + 2 * SW + CW;

   logic          gate;
   logic [SW-1:0] on_field;
   logic [SW-1:0] off_field;
   logic [CW-1:0] left_field;

   assign gate       = rsp_tdata[0];
   assign on_field   = rsp_tdata[ON_LO+SW-1:ON_LO];
   assign off_field  = rsp_tdata[OFF_LO+SW-1:OFF_LO];
   assign left_field = rsp_tdata[LEFT_LO+CW-1:LEFT_LO];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_route_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gate |-> off_field == '0)
      else $error("off-when-idle output active while idle");

   a_route_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !gate |-> on_field == '0)
      else $error("on-when-idle output active while not idle");

   a_left_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && gate |-> left_field == '0)
      else $error("frames left nonzero while idle");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind idle_timeout_gate itg_checker #(
   .COUNT_WIDTH  (COUNT_WIDTH),
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_itg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
